// File: rtl/rth_pkg.sv
// Package for the RGB to HSL converter: shared widths and the stage control struct.
// No dependencies.
package rth_pkg;

  localparam int unsigned PixW = 24;
  localparam int unsigned ChW  = 8;
  localparam int unsigned QW   = 19;

  typedef struct packed {
    logic valid;
  } stg_t;

endpackage

// File: rtl/rth_div.sv
// Restoring divider: one quotient bit per pipeline stage, unsigned, with side-band tag.
// Depends on rth_pkg.
module rth_div #(
  parameter int unsigned NumW = 17,
  parameter int unsigned DenW = 10,
  parameter int unsigned TagW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);
  import rth_pkg::*;

  logic               vld_q [1:NumW];
  logic [NumW-1:0]    num_q [1:NumW];
  logic [DenW:0]      rem_q [1:NumW];
  logic [DenW-1:0]    den_q [1:NumW];
  logic [TagW-1:0]    tag_q [1:NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_st
    logic            vin;
    logic [NumW-1:0] nin;
    logic [DenW:0]   rin;
    logic [DenW-1:0] din;
    logic [TagW-1:0] tin;
    logic [DenW+1:0] sh;
    logic [DenW+1:0] df;
    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign nin = num_i;
      assign rin = '0;
      assign din = den_i;
      assign tin = tag_i;
    end else begin : g_next
      assign vin = vld_q[k];
      assign nin = num_q[k];
      assign rin = rem_q[k];
      assign din = den_q[k];
      assign tin = tag_q[k];
    end
    always_comb begin
      sh = {rin, nin[NumW-1]};
      df = sh - {2'b00, din};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en_i) vld_q[k+1] <= vin;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1] <= din;
        tag_q[k+1] <= tin;
        if (!df[DenW+1]) begin
          rem_q[k+1] <= df[DenW:0];
          num_q[k+1] <= {nin[NumW-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= sh[DenW:0];
          num_q[k+1] <= {nin[NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o   = num_q[NumW];
  assign tag_o   = tag_q[NumW];
endmodule

// File: rtl/rgb_to_hsl_packed.sv
// RGB to HSL converter, top level. Throughput one pixel per cycle while not stalled.
// Stage 1: min/max and hue branch; stage 2: divider operands; 19 divider stages;
// final stage: clamp, sign, pack. Stall freezes the whole pipeline.
// Reset (async, active low) clears valid bits only; no kept state.
// Depends on rth_pkg and rth_div.
module rgb_to_hsl_packed (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [rth_pkg::PixW-1:0]  rgb_pixel_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic signed [8:0]         hue_value_o,
  output logic [7:0]                sat_value_o,
  output logic [7:0]                light_value_o,
  output logic [7:0]                luminance_value_o,
  output logic signed [8:0]         chroma_value_o,
  output logic signed [16:0]        packed_hsl16_o
);
  import rth_pkg::*;

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // stage 1
  logic [7:0] r, g, b, mx, mn;
  logic [1:0] br;
  always_comb begin
    r = rgb_pixel_i[23:16]; g = rgb_pixel_i[15:8]; b = rgb_pixel_i[7:0];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    br = (r == mx) ? 2'd0 : ((g == mx) ? 2'd1 : 2'd2);
  end

  stg_t s1_q;
  logic [7:0] d1_q;
  logic [8:0] sum1_q;
  logic signed [11:0] num1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_q.valid <= 1'b0;
    else if (en) s1_q.valid <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q   <= mx - mn;
      sum1_q <= {1'b0, mx} + {1'b0, mn};
      case (br)
        2'd0: num1_q <= $signed({4'b0, g}) - $signed({4'b0, b});
        2'd1: num1_q <= $signed({3'b0, mx - mn, 1'b0}) + $signed({4'b0, b})
                        - $signed({4'b0, r});
        default: num1_q <= $signed({2'b0, mx - mn, 2'b0}) + $signed({4'b0, r})
                        - $signed({4'b0, g});
      endcase
    end
  end

  // stage 2: operands. hue uses |256*num| / 6d, sat uses 256d / den; chroma |num|/6
  logic [9:0] sden;
  logic [10:0] anum;
  always_comb begin
    sden = sum1_q[8] ? (10'd512 - {1'b0, sum1_q}) : {1'b0, sum1_q};
    anum = num1_q[11] ? 11'(-num1_q) : num1_q[10:0];
  end

  stg_t s2_q;
  logic [QW-1:0] hn_q, sn_q;
  logic [10:0] hd_q;
  logic [9:0] sd_q;
  logic [10:0] cn_q;
  logic neg2_q, z2_q;
  logic [8:0] sum2_q;
  logic [7:0] d2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_q.valid <= 1'b0;
    else if (en) s2_q.valid <= s1_q.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hn_q   <= QW'({anum, 8'b0});
      hd_q   <= 11'({d1_q, 2'b0}) + 11'({d1_q, 1'b0});
      sn_q   <= QW'({d1_q, 8'b0});
      sd_q   <= (sden == 10'd0) ? 10'd1 : sden;
      cn_q   <= anum;
      neg2_q <= num1_q[11];
      z2_q   <= (d1_q == 8'd0);
      sum2_q <= sum1_q;
      d2_q   <= d1_q;
    end
  end

  localparam int unsigned TagW = 1 + 1 + 9 + 8 + 11;
  logic hv, sv;
  logic [QW-1:0] hq, sq;
  logic [TagW-1:0] htag, stag_unused;
  logic [TagW-1:0] tag_in;
  assign tag_in = {neg2_q, z2_q, sum2_q, d2_q, cn_q};

  rth_div #(.NumW(QW), .DenW(11), .TagW(TagW)) u_hdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s2_q.valid), .num_i(hn_q), .den_i(hd_q),
    .tag_i(tag_in), .valid_o(hv), .quo_o(hq), .tag_o(htag));
  rth_div #(.NumW(QW), .DenW(10), .TagW(TagW)) u_sdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s2_q.valid), .num_i(sn_q), .den_i(sd_q),
    .tag_i(tag_in), .valid_o(sv), .quo_o(sq), .tag_o(stag_unused));

  // final stage
  logic neg, z;
  logic [8:0] sum;
  logic [7:0] dd, light, sat, s;
  logic [10:0] cn;
  logic [7:0] cq;
  logic signed [8:0] hue, chroma, hq4;
  always_comb begin
    {neg, z, sum, dd, cn} = htag;
    light = sum[8:1];
    sat = z ? 8'd0 : ((sq > QW'(255)) ? 8'd255 : sq[7:0]);
    // divide by 6 via 683/4096, exact for the numerator range
    cq = 8'(({9'b0, cn} * 20'd683) >> 12);
    hue = z ? 9'sd0 : (neg ? -$signed({1'b0, hq[7:0]}) : $signed(hq[8:0]));
    chroma = z ? 9'sd0 : (neg ? -$signed({1'b0, cq}) : $signed({1'b0, cq}));
    s = sat;
    if (light > 8'd179) s = s >> 1;
    if (light > 8'd192) s = s >> 1;
    if (light > 8'd217) s = s >> 1;
    if (light > 8'd243) s = s >> 1;
    hq4 = (hue < 0) ? -((-hue) >>> 2) : (hue >>> 2);
  end

  logic vo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en) vo_q <= hv & sv;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_value_o       <= hue;
      chroma_value_o    <= chroma;
      sat_value_o       <= sat;
      light_value_o     <= light;
      luminance_value_o <= z ? 8'd1 : dd;
      packed_hsl16_o    <= 17'(hq4 * 1024) + 17'({s[7:5], 7'b0}) + 17'(light[7:1]);
    end
  end
  assign valid_o = vo_q;
endmodule
